// ===== hw/rtl/covariance_matrix_engine_defines.svh =====
// Assertion macros shared by the covariance matrix engine RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef COVARIANCE_MATRIX_ENGINE_DEFINES_SVH
`define COVARIANCE_MATRIX_ENGINE_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define CME_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Asserts that an antecedent implies a consequent in the next cycle.
`define CME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cme_pkg.sv =====
// Package for the covariance matrix engine: sizes, register map and shared types.
// Depends on nothing.
package cme_pkg;
  localparam int unsigned DefMaxDim    = 4;
  localparam int unsigned DefMaxRows   = 65535;
  localparam int unsigned DefSampleBits = 16;
  localparam int unsigned DefFracBits  = 8;
  localparam int unsigned InWidth      = 16;
  localparam int unsigned CovWidth     = 41;
  localparam int unsigned DimWidth     = 3;
  localparam int unsigned IdxWidth     = 2;
  localparam int unsigned DivWidth     = 128;

  localparam logic [0:0] RegDimAddr = 1'b0;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_NUM,
    ST_NUM2,
    ST_DIV,
    ST_OUT
  } cme_state_t;

  // Control from the sequencer to the lanes.
  typedef struct packed {
    logic accept;
    logic clear;
  } cme_lane_ctl_t;
endpackage

// ===== hw/rtl/covariance_matrix_engine.sv =====
// Covariance matrix engine: one row accepted per cycle into parallel lanes while accumulating.
// On the last row, each of d*d entries passes through the setup states ST_NUM and ST_NUM2,
// a restoring division of the numerator magnitude and a hand-off state ST_OUT that waits for m_tready.
// No rows are taken during emission.
// Synchronous active-high reset clears all sums, the count and sets dimension to MAX_DIM.
module covariance_matrix_engine
  import cme_pkg::*;
#(
  parameter int unsigned MAX_DIM     = DefMaxDim,
  parameter int unsigned MAX_ROWS    = DefMaxRows,
  parameter int unsigned SAMPLE_BITS = DefSampleBits,
  parameter int unsigned FRAC_BITS   = DefFracBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // value_0, value_1, value_2, value_3
  input  logic        s_tlast,  // last_row
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // matrix_row, matrix_col, covariance, zero fill
  output logic        m_tuser,  // count_overflow
  output logic        m_tlast,  // last_entry
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
`include "covariance_matrix_engine_defines.svh"

  localparam int unsigned CntBits  = $clog2(MAX_ROWS + 1);
  localparam int unsigned SumBits  = SAMPLE_BITS + CntBits + 1;
  localparam int unsigned XBits    = 2*SAMPLE_BITS + CntBits + 1;
  localparam int unsigned NumBits  = XBits + CntBits + 2;
  localparam int unsigned DenBits  = 2*CntBits;
  localparam int unsigned DivBits  = NumBits + FRAC_BITS;
  localparam int unsigned LIdx     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [CovWidth-1:0] PosMax = {1'b0, {(CovWidth-1){1'b1}}};
  localparam logic [CovWidth-1:0] NegMin = {1'b1, {(CovWidth-1){1'b0}}};

  logic [DimWidth-1:0] dim_reg;
  logic                cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegDimAddr);
  always_ff @(posedge clk) begin
    if (rst) dim_reg <= DimWidth'(MAX_DIM);
    else if (cfg_we) dim_reg <= pwdata[DimWidth-1:0];
  end
  assign prdata = (paddr[2] == RegDimAddr) ? 32'(dim_reg) : '0;

  logic signed [MAX_DIM-1:0][SAMPLE_BITS-1:0] samples;
  for (genvar i = 0; i < MAX_DIM; i++) begin : g_s
    if (i < 4) begin : g_in
      assign samples[i] = s_tdata[i*InWidth +: SAMPLE_BITS];
    end else begin : g_z
      assign samples[i] = '0;
    end
  end

  cme_state_t state, state_next;
  logic [CntBits-1:0] row_count;
  logic overflow_seen;
  logic in_acc;
  cme_lane_ctl_t lane_ctl;
  logic full;

  assign s_tready = (state == ST_ACCUM);
  assign in_acc = s_tvalid && s_tready;
  assign full = (row_count == CntBits'(MAX_ROWS));
  assign lane_ctl.accept = in_acc && !full;

  logic signed [MAX_DIM-1:0][SumBits-1:0] col_sum;
  logic signed [MAX_DIM-1:0][MAX_DIM-1:0][XBits-1:0] cross_sum;
  for (genvar l = 0; l < MAX_DIM; l++) begin : g_lane
    cme_lane #(.MAX_DIM(MAX_DIM), .SAMPLE_BITS(SAMPLE_BITS), .SUM_BITS(SumBits),
               .XSUM_BITS(XBits), .LANE(l)) u_lane (
      .clk(clk), .ctl(lane_ctl), .samples(samples),
      .col_sum(col_sum[l]), .cross_sum(cross_sum[l]));
  end

  // Emission indices and merge of lane results.
  logic [LIdx-1:0] ri, ci;
  logic [DimWidth-1:0] dim_eff;
  logic last_pos;
  always_comb begin
    if (dim_reg == '0) dim_eff = DimWidth'(1);
    else if (32'(dim_reg) > MAX_DIM) dim_eff = DimWidth'(MAX_DIM);
    else dim_eff = dim_reg;
  end
  assign last_pos = (DimWidth'(ri) == dim_eff - 1'b1) && (DimWidth'(ci) == dim_eff - 1'b1);

  logic signed [XBits-1:0] sxy_sel;
  logic signed [SumBits-1:0] sx_sel, sy_sel;
  assign sxy_sel = (ri <= ci) ? cross_sum[ri][ci] : cross_sum[ci][ri];
  assign sx_sel = col_sum[ri];
  assign sy_sel = col_sum[ci];

  logic signed [NumBits-1:0] p1, p2, num;
  logic [DenBits-1:0] den;
  logic neg;
  logic [NumBits-1:0] mag;
  always_ff @(posedge clk) begin
    if (state == ST_NUM) begin
      p1  <= NumBits'($signed({1'b0, row_count}) * sxy_sel);
      p2  <= NumBits'(sx_sel * sy_sel);
      den <= DenBits'(row_count * (row_count - 1'b1));
    end
  end
  // The products hold until the next entry, so the sign stays valid through the division.
  assign num = p1 - p2;
  assign neg = num[NumBits-1];
  assign mag = neg ? NumBits'(-num) : num;

  logic div_start, div_done;
  logic [DivBits-1:0] quot;
  cme_div #(.NUM_BITS(DivBits), .DEN_BITS(DenBits)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({mag, {FRAC_BITS{1'b0}}}), .den(den), .done(div_done), .quot(quot));

  // Saturate the quotient to the signed output range.
  logic [CovWidth-1:0] cov_val;
  logic big;
  assign big = (quot > DivBits'(NegMin));
  always_comb begin
    if (row_count < CntBits'(2)) cov_val = '0;
    else if (neg) cov_val = big ? NegMin : CovWidth'(-quot);
    else cov_val = (quot > DivBits'(PosMax)) ? PosMax : quot[CovWidth-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM: if (in_acc && s_tlast) state_next = ST_NUM;
      ST_NUM:   state_next = ST_NUM2;
      ST_NUM2:  state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_OUT;
      ST_OUT:   if (m_tready) state_next = last_pos ? ST_ACCUM : ST_NUM;
      default:  state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    div_start = (state == ST_NUM2);
    lane_ctl.clear = rst || (state == ST_OUT && m_tready && last_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      row_count <= '0;
      overflow_seen <= 1'b0;
      ri <= '0;
      ci <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (lane_ctl.accept) row_count <= row_count + 1'b1;
      if (in_acc && full) overflow_seen <= 1'b1;
      if (state == ST_DIV && div_done) m_tvalid <= 1'b1;
      if (state == ST_OUT && m_tready) begin
        m_tvalid <= 1'b0;
        if (last_pos) begin
          ri <= '0;
          ci <= '0;
          row_count <= '0;
          overflow_seen <= 1'b0;
        end else if (DimWidth'(ci) == dim_eff - 1'b1) begin
          ci <= '0;
          ri <= ri + 1'b1;
        end else begin
          ci <= ci + 1'b1;
        end
      end
    end
  end

  logic [CovWidth-1:0] cov_out;
  logic [IdxWidth-1:0] r_out, c_out;
  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_done) begin
      cov_out <= cov_val;
      r_out   <= IdxWidth'(ri);
      c_out   <= IdxWidth'(ci);
      m_tuser <= overflow_seen;
      m_tlast <= last_pos;
    end
  end
  assign m_tdata = {3'b000, cov_out, c_out, r_out};

  `CME_ASSERT_IMPL(a_no_in_busy, clk, rst, state != ST_ACCUM, !s_tready,
                   "input ready while emitting")
  `CME_ASSERT_IMPL(a_valid_out, clk, rst, m_tvalid, state == ST_OUT,
                   "output valid outside output state")
  `CME_ASSERT_NEXT(a_clear, clk, rst, m_tvalid && m_tready && m_tlast,
                   row_count == '0, "count not cleared after matrix")
endmodule

// ===== hw/rtl/cme_lane.sv =====
// One accumulation lane: column sum and the cross sums of its column against
// the columns at or above it. Depends on cme_pkg.
module cme_lane
  import cme_pkg::*;
#(
  parameter int unsigned MAX_DIM     = DefMaxDim,
  parameter int unsigned SAMPLE_BITS = DefSampleBits,
  parameter int unsigned SUM_BITS    = 48,
  parameter int unsigned XSUM_BITS   = 64,
  parameter int unsigned LANE        = 0
) (
  input  logic                                   clk,
  input  cme_lane_ctl_t                          ctl,
  input  logic signed [MAX_DIM-1:0][SAMPLE_BITS-1:0] samples,
  output logic signed [SUM_BITS-1:0]             col_sum,
  output logic signed [MAX_DIM-1:0][XSUM_BITS-1:0] cross_sum
);
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      col_sum <= '0;
    end else if (ctl.accept) begin
      col_sum <= col_sum + SUM_BITS'($signed(samples[LANE]));
    end
  end

  // Entries below this lane's column stay zero and are never read.
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_x
    if (j >= LANE) begin : g_u
      logic signed [2*SAMPLE_BITS-1:0] prod;
      logic signed [XSUM_BITS-1:0]     acc;
      assign prod = $signed(samples[LANE]) * $signed(samples[j]);
      always_ff @(posedge clk) begin
        if (ctl.clear) begin
          acc <= '0;
        end else if (ctl.accept) begin
          acc <= acc + XSUM_BITS'(prod);
        end
      end
      assign cross_sum[j] = acc;
    end else begin : g_l
      assign cross_sum[j] = '0;
    end
  end
endmodule

// ===== hw/rtl/cme_div.sv =====
// Radix-2 restoring divider for the covariance numerator magnitude.
// Depends on cme_pkg.
module cme_div
  import cme_pkg::*;
#(
  parameter int unsigned NUM_BITS = 96,
  parameter int unsigned DEN_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);
  localparam int unsigned CntBits = $clog2(NUM_BITS + 1);
  logic [CntBits-1:0]  cnt;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS:0]   trial;
  logic                busy;

  assign trial = {rem[DEN_BITS-1:0], quot[NUM_BITS-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntBits'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
    end else if (busy) begin
      if (!trial[DEN_BITS]) begin
        rem  <= trial;
        quot <= {quot[NUM_BITS-2:0], 1'b1};
      end else begin
        rem  <= {rem[DEN_BITS-1:0], quot[NUM_BITS-1]};
        quot <= {quot[NUM_BITS-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== tb/cme_checker.sv =====
// Checker for the covariance matrix engine: watches the row, matrix and APB channels,
// predicts every matrix entry and compares it with what the block emits.
// Depends on cme_pkg for the register address and field widths.
module cme_checker
  import cme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          entries_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RowLimit = DefMaxRows;

  typedef struct {
    logic [IdxWidth-1:0] row;
    logic [IdxWidth-1:0] col;
    logic [CovWidth-1:0] cov;
    logic                ovf;
    logic                lst;
  } entry_t;

  entry_t entry_queue[$];
  logic [DimWidth-1:0] dim_reg;
  int unsigned rows_taken;
  longint col_sum[4];
  longint cross_sum[4][4];
  bit sat_seen;

  assign entries_pending = entry_queue.size();

  function automatic logic [CovWidth-1:0] cov_value(int a, int b);
    logic [63:0] n, num, mag, den, q, r, res;
    bit neg;
    n = 64'(rows_taken);
    if (n < 2) return '0;
    num = n * 64'(cross_sum[a][b]) - 64'(col_sum[a]) * 64'(col_sum[b]);
    neg = num[63];
    mag = neg ? -num : num;
    den = n * (n - 1);
    q = mag / den;
    r = mag % den;
    // Quotients this large saturate before the fraction bits are added.
    if (q > (64'd1 << (CovWidth - 1 - DefFracBits)))
      res = 64'd1 << (CovWidth - 1);
    else
      res = (q << DefFracBits) + ((r << DefFracBits) / den);
    if (neg) begin
      if (res > (64'd1 << (CovWidth - 1))) res = 64'd1 << (CovWidth - 1);
      return CovWidth'(-res);
    end
    if (res > ((64'd1 << (CovWidth - 1)) - 1)) res = (64'd1 << (CovWidth - 1)) - 1;
    return CovWidth'(res);
  endfunction

  task automatic clear_sums();
    rows_taken = 0;
    sat_seen = 0;
    for (int i = 0; i < 4; i++) begin
      col_sum[i] = 0;
      for (int j = 0; j < 4; j++) cross_sum[i][j] = 0;
    end
  endtask

  task automatic take_row(logic [63:0] d, logic l);
    longint v[4];
    int dim;
    entry_t e;
    for (int i = 0; i < 4; i++) v[i] = longint'($signed(d[16*i +: 16]));
    if (rows_taken >= RowLimit) begin
      sat_seen = 1;
    end else begin
      rows_taken++;
      for (int i = 0; i < 4; i++) begin
        col_sum[i] += v[i];
        for (int j = 0; j < 4; j++) cross_sum[i][j] += v[i] * v[j];
      end
    end
    if (!l) return;
    dim = (dim_reg == 0) ? 1 : (dim_reg > 4) ? 4 : int'(dim_reg);
    for (int i = 0; i < dim; i++) begin
      for (int j = 0; j < dim; j++) begin
        e.row = IdxWidth'(i);
        e.col = IdxWidth'(j);
        e.cov = cov_value(i, j);
        e.ovf = sat_seen;
        e.lst = (i == dim - 1) && (j == dim - 1);
        entry_queue.push_back(e);
      end
    end
    clear_sums();
  endtask

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch at %0t: %s expected %0h actual %0h", $realtime, what, exp_v, act_v);
  endtask

  initial begin
    fail_count = 0;
    dim_reg = 3'd4;
    clear_sums();
  end

  always @(posedge clk) begin
    entry_t e;
    if (rst) begin
      dim_reg <= 3'd4;
      clear_sums();
      entry_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(RegDimAddr))
        dim_reg <= pwdata[DimWidth-1:0];
      if (s_tvalid && s_tready) take_row(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (entry_queue.size() == 0) begin
          report("unexpected entry", 0, m_tdata);
        end else begin
          e = entry_queue.pop_front();
          if (m_tdata[1:0] !== e.row) report("matrix_row", e.row, m_tdata[1:0]);
          if (m_tdata[3:2] !== e.col) report("matrix_col", e.col, m_tdata[3:2]);
          if (m_tdata[44:4] !== e.cov) report("covariance", e.cov, m_tdata[44:4]);
          if (m_tdata[47:45] !== 3'b000) report("zero fill", 0, m_tdata[47:45]);
          if (m_tuser !== e.ovf) report("count_overflow", e.ovf, m_tuser);
          if (m_tlast !== e.lst) report("last_entry", e.lst, m_tlast);
        end
      end
    end
  end
endmodule

// ===== tb/tb_covariance_matrix_engine.sv =====
// Testbench top for the covariance matrix engine: clock, reset, row stimulus,
// APB register writes and the verdict. Depends on cme_pkg and cme_checker.
module tb_covariance_matrix_engine;
  import cme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;  // value_0, value_1, value_2, value_3
  logic        s_tlast;  // last_row
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;  // matrix_row, matrix_col, covariance, zero fill
  logic        m_tuser;  // count_overflow
  logic        m_tlast;  // last_entry
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          entries_pending;
  int          src_idle;
  int          snk_idle;
  bit          sink_hold;

  covariance_matrix_engine u_top (.*);

  cme_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .m_tlast, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .entries_pending
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    if (rst || sink_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom % 100) >= snk_idle;
    end
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom % 7)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_row();
    return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_row(logic [63:0] d, logic l);
    while (($urandom % 100) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_set(int rows);
    for (int i = 0; i < rows; i++) send_row(pick_row(), i == rows - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (entries_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_dim(logic [2:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(RegDimAddr);
    pwdata <= {29'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [2:0] dims[6] = '{3'd4, 3'd1, 3'd2, 3'd0, 3'd3, 3'd7};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sink_hold = 1'b0;
    src_idle = 0;
    snk_idle = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: single row and empty-ish sets give zeros; extremes of every column.
    write_dim(3'd4);
    send_row({4{16'h8000}}, 1'b1);
    send_row({4{16'h7fff}}, 1'b0);
    send_row({4{16'h8000}}, 1'b1);
    send_row({16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 1'b0);
    send_row({16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 1'b0);
    send_row(64'h0001_ffff_0000_0003, 1'b1);
    send_row(64'hffff_ffff_ffff_ffff, 1'b0);
    send_row(64'h0000_0000_0000_0000, 1'b0);
    send_row(64'h0002_0001_0003_0001, 1'b1);
    write_dim(3'd0);
    send_row(64'h0000_0000_0000_0005, 1'b0);
    send_row(64'h0000_0000_0000_0002, 1'b1);
    write_dim(3'd6);
    send_row(64'h1234_8765_5555_aaaa, 1'b0);
    send_row(64'hedcb_789a_aaaa_5555, 1'b1);

    // Random sets: first the receiver idles more, then the sender, then neither.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 35 : (phase == 1) ? 51 : 0;
      snk_idle = (phase == 0) ? 51 : (phase == 1) ? 35 : 0;
      for (int k = 0; k < 6; k++) begin
        write_dim(dims[(phase * 2 + k) % 6]);
        for (int s = 0; s < 3; s++) send_set($urandom_range(1, 7));
        if (k == 2) begin
          // Receiver stalls for a long stretch while rows keep coming.
          fork
            begin
              sink_hold = 1'b1;
              repeat (400) @(negedge clk);
              sink_hold = 1'b0;
            end
          join_none
          send_set(2);
          send_set(4);
          drain();
        end
      end
    end

    write_dim(3'd4);
    send_set(3);
    write_dim(3'd7);

    drain();
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cme_pkg.sv
hw/rtl/cme_lane.sv
hw/rtl/cme_div.sv
hw/rtl/covariance_matrix_engine.sv
tb/cme_checker.sv
tb/tb_covariance_matrix_engine.sv
